// File: src/sosf_pkg.sv
// Shared types and constants for the second-order smoothing filter.
package sosf_pkg;

    localparam int SAMPLE_W  = 32;
    localparam int FACTOR_W  = 17;
    localparam int SQ_W      = 2 * FACTOR_W - 1;      // a*a and b*b stay within 2^32
    localparam int OPA_W     = SQ_W + 1;
    localparam int OPB_W     = SAMPLE_W + 1;
    localparam int PROD_W    = OPA_W + OPB_W;
    localparam int ACC_W     = PROD_W + 1;
    localparam int X1_SHIFT  = 17;                    // 2a in Q0.32 is a << 17
    localparam int FRAC_OUT  = 32;                    // Q0.32 coefficient scaling

    localparam logic [FACTOR_W-1:0] FACTOR_ONE = FACTOR_W'(65536);

    localparam logic [1:0] REG_FILTER_FACTOR = 2'd0;
    localparam logic [1:0] REG_HIGH_LIMIT    = 2'd1;
    localparam logic [1:0] REG_LOW_LIMIT     = 2'd2;
    localparam logic [1:0] REG_AUTO_MODE     = 2'd3;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_AA,      // a * a
        MUL_BB,      // b * b, keeps a*a
        MUL_X2,      // a*a * x2, keeps b*b
        MUL_X0,      // b*b * x
        MUL_X1       // a * x1
    } mul_step_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD_NEG,
        ACC_ADD,
        ACC_ADD_SHIFT
    } acc_op_t;

    typedef struct packed {
        mul_step_t mul_step;
        acc_op_t   acc_op;
    } mac_ctrl_t;

endpackage

// File: src/second_order_smoothing_filter_unit.sv
// Top level of the second-order smoothing filter with limit alarm.
//
// Input stream s_*: one signed Q16.16 sample per transaction in s_tdata.
// Output stream m_*: one result per input, the filtered value and an alarm bit
// that is set when the value lies above high_limit or below low_limit.
// Configuration: cfg_we writes cfg_wdata to register cfg_index
// (0 filter_factor, 1 high_limit, 2 low_limit, 3 auto_mode).
// In auto mode a sample reaches the result register after five passes
// through the one shared 34x33 multiplier (a*a, b*b, a*a*x2, b*b*x, a*x1),
// then the accumulate state S_SUM, the saturation state S_SAT and the output
// state S_OUT. In manual mode a sample goes from idle straight to S_OUT.
// The next sample can be taken in the cycle after the result loads; until
// then no new sample is accepted.
// s_tready is high only while the sequencer is idle, so one sample is in work
// at a time. The output register holds a result until m_tready takes it; a
// finished sample waits in the output state while the previous result is
// still pending, and the sequencer does not return to idle until then.
// Reset clears history, held output and registers to their defaults
// (a = 0.5, high limit 100.0, low limit 0.0, auto mode).
module second_order_smoothing_filter_unit import sosf_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,     // [31:0] sample
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,     // [31:0] filtered, [32] over_limit, [39:33] zero
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_AA,
        S_BB,
        S_X2,
        S_X0,
        S_X1,
        S_SUM,
        S_SAT,
        S_OUT
    } state_t;

    state_t                      state_reg;
    logic [FACTOR_W-1:0]         factor_reg;
    logic signed [SAMPLE_W-1:0]  high_reg;
    logic signed [SAMPLE_W-1:0]  low_reg;
    logic                        auto_reg;
    logic signed [SAMPLE_W-1:0]  x_reg;
    logic signed [SAMPLE_W-1:0]  prev_reg;
    logic signed [SAMPLE_W-1:0]  older_reg;
    logic signed [SAMPLE_W-1:0]  held_reg;
    logic                        m_valid_reg;
    logic signed [SAMPLE_W-1:0]  m_filtered_reg;
    logic                        m_over_reg;

    mac_ctrl_t                   mac_ctrl;
    logic signed [ACC_W-1:0]     acc;
    logic signed [ACC_W-FRAC_OUT-1:0] sum_int;
    logic signed [SAMPLE_W-1:0]  sum_sat;
    logic                        out_free;

    always_comb begin
        mac_ctrl = '{mul_step: MUL_NONE, acc_op: ACC_HOLD};
        unique case (state_reg)
            S_AA:    mac_ctrl = '{mul_step: MUL_AA, acc_op: ACC_HOLD};
            S_BB:    mac_ctrl = '{mul_step: MUL_BB, acc_op: ACC_HOLD};
            S_X2:    mac_ctrl = '{mul_step: MUL_X2, acc_op: ACC_HOLD};
            S_X0:    mac_ctrl = '{mul_step: MUL_X0, acc_op: ACC_LOAD_NEG};
            S_X1:    mac_ctrl = '{mul_step: MUL_X1, acc_op: ACC_ADD};
            S_SUM:   mac_ctrl = '{mul_step: MUL_NONE, acc_op: ACC_ADD_SHIFT};
            default: mac_ctrl = '{mul_step: MUL_NONE, acc_op: ACC_HOLD};
        endcase
    end

    sosf_mac u_mac (
        .aclk          (aclk),
        .ctrl          (mac_ctrl),
        .filter_factor (factor_reg),
        .x0            (x_reg),
        .x1            (prev_reg),
        .x2            (older_reg),
        .acc           (acc)
    );

    // exact sum is Q.48; arithmetic shift gives the floor
    assign sum_int = acc[ACC_W-1:FRAC_OUT];

    always_comb begin
        if (sum_int[ACC_W-FRAC_OUT-1:SAMPLE_W-1] == '0 ||
            sum_int[ACC_W-FRAC_OUT-1:SAMPLE_W-1] == '1) begin
            sum_sat = sum_int[SAMPLE_W-1:0];
        end else if (sum_int[ACC_W-FRAC_OUT-1]) begin
            sum_sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end else begin
            sum_sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
    end

    assign out_free = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            factor_reg  <= FACTOR_W'(32768);
            high_reg    <= SAMPLE_W'(6553600);
            low_reg     <= '0;
            auto_reg    <= 1'b1;
            prev_reg    <= '0;
            older_reg   <= '0;
            held_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_FILTER_FACTOR: factor_reg <= cfg_wdata[FACTOR_W-1:0];
                    REG_HIGH_LIMIT:    high_reg   <= cfg_wdata;
                    REG_LOW_LIMIT:     low_reg    <= cfg_wdata;
                    REG_AUTO_MODE:     auto_reg   <= cfg_wdata[0];
                    default:           ;
                endcase
            end

            // in S_OUT the output register is reloaded instead
            if (m_valid_reg && m_tready && (state_reg != S_OUT)) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        x_reg     <= s_tdata;
                        state_reg <= auto_reg ? S_AA : S_OUT;
                    end
                end
                S_AA:  state_reg <= S_BB;
                S_BB:  state_reg <= S_X2;
                S_X2:  state_reg <= S_X0;
                S_X0:  state_reg <= S_X1;
                S_X1:  state_reg <= S_SUM;
                S_SUM: state_reg <= S_SAT;
                S_SAT: begin
                    held_reg  <= sum_sat;
                    older_reg <= prev_reg;
                    prev_reg  <= x_reg;
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        m_valid_reg    <= 1'b1;
                        m_filtered_reg <= held_reg;
                        m_over_reg     <= (held_reg > high_reg) || (held_reg < low_reg);
                        state_reg      <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0, m_over_reg, m_filtered_reg};

endmodule

// File: src/sosf_mac.sv
// Shared multiply-accumulate unit of the filter: one registered product per cycle.
module sosf_mac import sosf_pkg::*; (
    input  logic                       aclk,
    input  mac_ctrl_t                  ctrl,
    input  logic [FACTOR_W-1:0]        filter_factor,
    input  logic signed [SAMPLE_W-1:0] x0,
    input  logic signed [SAMPLE_W-1:0] x1,
    input  logic signed [SAMPLE_W-1:0] x2,
    output logic signed [ACC_W-1:0]    acc
);

    logic [FACTOR_W-1:0]      a_eff;
    logic [FACTOR_W-1:0]      b_eff;
    logic [SQ_W-1:0]          sq_a_reg;
    logic [SQ_W-1:0]          sq_b_reg;
    logic signed [OPA_W-1:0]  op_a;
    logic signed [OPB_W-1:0]  op_b;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  prod_ext;

    // factor above one is used as one
    assign a_eff = (filter_factor > FACTOR_ONE) ? FACTOR_ONE : filter_factor;
    assign b_eff = FACTOR_ONE - a_eff;

    always_comb begin
        op_a = '0;
        op_b = '0;
        case (ctrl.mul_step)
            MUL_AA: begin
                op_a = signed'(OPA_W'(a_eff));
                op_b = signed'(OPB_W'(a_eff));
            end
            MUL_BB: begin
                op_a = signed'(OPA_W'(b_eff));
                op_b = signed'(OPB_W'(b_eff));
            end
            MUL_X2: begin
                op_a = signed'(OPA_W'(sq_a_reg));
                op_b = OPB_W'(x2);
            end
            MUL_X0: begin
                op_a = signed'(OPA_W'(sq_b_reg));
                op_b = OPB_W'(x0);
            end
            MUL_X1: begin
                op_a = signed'(OPA_W'(a_eff));
                op_b = OPB_W'(x1);
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign prod_ext = ACC_W'(prod_reg);

    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
        if (ctrl.mul_step == MUL_BB) begin
            sq_a_reg <= prod_reg[SQ_W-1:0];
        end
        if (ctrl.mul_step == MUL_X2) begin
            sq_b_reg <= prod_reg[SQ_W-1:0];
        end
        case (ctrl.acc_op)
            ACC_LOAD_NEG:  acc_reg <= -prod_ext;
            ACC_ADD:       acc_reg <= acc_reg + prod_ext;
            ACC_ADD_SHIFT: acc_reg <= acc_reg + (prod_ext <<< X1_SHIFT);
            default:       acc_reg <= acc_reg;
        endcase
    end

    assign acc = acc_reg;

endmodule
